// File: hw/rtl/rtbh_pkg.sv
// Shared types, widths and the back end's operation sequence for the ray/triangle hit block.
// Used by every module of the block; depends on nothing.
package rtbh_pkg;

    // Field and arithmetic widths.
    localparam int COORD_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int DIST_W       = 26;
    localparam int SEARCH_STEPS = 20;
    localparam int STEP_W       = $clog2(SEARCH_STEPS + 1);
    localparam logic [DIST_W-1:0] DIST_MAX = 26'd65536000;

    localparam int EDGE_W = COORD_W + 1;
    localparam int NRM_W  = 68;
    localparam int DOT_W  = 104;
    localparam int DP_W   = 64;
    localparam int BARY_W = 100;
    localparam int SUM_W  = BARY_W + 2;

    // Digit-serial multiply-accumulate unit.
    localparam int ACC_W   = 176;
    localparam int A_W     = 104;
    localparam int B_W     = 72;
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = B_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation sequence.
    localparam int PC_W = 5;

    localparam logic       MODE_TRACE   = 1'b1;
    localparam logic [1:0] VERTEX_COUNT = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [1:0]        vertex_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } result_t;

    typedef struct packed {
        logic                    start;
        logic                    keep;
        logic                    neg;
        logic signed [A_W-1:0]   a;
        logic signed [B_W-1:0]   b;
        logic signed [ACC_W-1:0] init;
    } mac_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } mac_rsp_t;

    typedef enum logic [3:0] {
        A_E1X, A_E1Y, A_E1Z, A_NX, A_NY, A_NZ, A_DIST, A_T,
        A_D0X, A_D0Y, A_DPX, A_DPY
    } a_sel_t;

    typedef enum logic [3:0] {
        B_E2X, B_E2Y, B_E2Z, B_RELX, B_RELY, B_RELZ, B_DIRX, B_DIRY,
        B_DIRZ, B_MID, B_D1X, B_D1Y, B_D0X, B_D0Y
    } b_sel_t;

    typedef enum logic [1:0] {
        I_CLEAR, I_KEEP, I_RDIST, I_PX
    } init_t;

    typedef enum logic [3:0] {
        D_NONE, D_NX, D_NY, D_NZ, D_R, D_D, D_SIGN, D_DPX, D_DPY,
        D_DET, D_U, D_V
    } dest_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        init_t  init;
        logic   neg;
        dest_t  dest;
    } uop_t;

    // One product per entry: normal, plane distances, bisection, barycentric terms.
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = '{A_E1Y, B_E2Z, I_CLEAR, 1'b0, D_NONE};
            5'd1:    u = '{A_E1Z, B_E2Y, I_KEEP,  1'b1, D_NX};
            5'd2:    u = '{A_E1Z, B_E2X, I_CLEAR, 1'b0, D_NONE};
            5'd3:    u = '{A_E1X, B_E2Z, I_KEEP,  1'b1, D_NY};
            5'd4:    u = '{A_E1X, B_E2Y, I_CLEAR, 1'b0, D_NONE};
            5'd5:    u = '{A_E1Y, B_E2X, I_KEEP,  1'b1, D_NZ};
            5'd6:    u = '{A_NX,  B_RELX, I_CLEAR, 1'b0, D_NONE};
            5'd7:    u = '{A_NY,  B_RELY, I_KEEP,  1'b0, D_NONE};
            5'd8:    u = '{A_NZ,  B_RELZ, I_KEEP,  1'b0, D_R};
            5'd9:    u = '{A_NX,  B_DIRX, I_CLEAR, 1'b0, D_NONE};
            5'd10:   u = '{A_NY,  B_DIRY, I_KEEP,  1'b0, D_NONE};
            5'd11:   u = '{A_NZ,  B_DIRZ, I_KEEP,  1'b0, D_D};
            5'd12:   u = '{A_DIST, B_MID, I_RDIST, 1'b0, D_SIGN};
            5'd13:   u = '{A_T,   B_DIRX, I_PX,    1'b0, D_DPX};
            5'd14:   u = '{A_T,   B_DIRY, I_PX,    1'b0, D_DPY};
            5'd15:   u = '{A_D0X, B_D1Y, I_CLEAR, 1'b0, D_NONE};
            5'd16:   u = '{A_D0Y, B_D1X, I_KEEP,  1'b1, D_DET};
            5'd17:   u = '{A_DPX, B_D1Y, I_CLEAR, 1'b0, D_NONE};
            5'd18:   u = '{A_DPY, B_D1X, I_KEEP,  1'b1, D_U};
            5'd19:   u = '{A_DPY, B_D0X, I_CLEAR, 1'b0, D_NONE};
            5'd20:   u = '{A_DPX, B_D0Y, I_KEEP,  1'b1, D_V};
            default: u = '{A_E1X, B_E2X, I_CLEAR, 1'b0, D_V};
        endcase
        return u;
    endfunction

endpackage

// File: hw/rtl/rtbh_front.sv
// Front end: accepts input words, drops loads of a nonexistent vertex, feeds the queue.
// Depends on rtbh_pkg.
module rtbh_front
    import rtbh_pkg::*;
(
    input  logic  item_valid,
    input  item_t item,
    output logic  item_stall,
    input  logic  q_full,
    output logic  push,
    output item_t push_item
);

    // A load of vertex three has no effect, so it never enters the queue.
    logic useful;

    always_comb
    begin
        useful     = (item.mode == MODE_TRACE) || (item.vertex_index < VERTEX_COUNT);
        item_stall = q_full;
        push       = item_valid && !q_full && useful;
        push_item  = item;
    end

endmodule

// File: hw/rtl/rtbh_queue.sv
// Short first-in first-out queue of accepted words between the front and back ends.
// Depends on rtbh_pkg.
module rtbh_queue
    import rtbh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  nonempty,
    output item_t head
);

    item_t mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

endmodule

// File: hw/rtl/rtbh_mac.sv
// Digit-serial signed multiply-accumulate unit, one 8-bit digit of the B operand per cycle.
// Depends on rtbh_pkg.
module rtbh_mac
    import rtbh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_req_t req,
    output mac_rsp_t rsp
);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] a_reg, a_next;
    logic signed [B_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    last;
    logic signed [DIGIT_W:0] digit;
    logic signed [ACC_W-1:0] pp;

    // The top digit carries the sign of B; the others are unsigned.
    always_comb
    begin
        last  = (cnt_reg == CNT_W'(DIGITS - 1));
        digit = last ? signed'(b_reg[DIGIT_W:0]) : signed'({1'b0, b_reg[DIGIT_W-1:0]});
        pp    = a_reg * digit;
    end

    // Load on start, then add one partial product per cycle.
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = req.keep ? acc_reg : req.init;
            a_next    = req.neg ? -ACC_W'(req.a) : ACC_W'(req.a);
            b_next    = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp;
            a_next   = a_reg <<< DIGIT_W;
            b_next   = b_reg >>> DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;

endmodule

// File: hw/rtl/rtbh_back.sv
// Back end: vertex store, operation sequencer over the shared MAC, bisection and hit decision.
// Depends on rtbh_pkg and rtbh_mac.
module rtbh_back
    import rtbh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_nonempty,
    input  item_t   q_head,
    output logic    pop,
    output logic    result_valid,
    output result_t result,
    input  logic    result_stall
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ISSUE  = 5'b00010,
        S_WAIT   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rneg_reg, rneg_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    result_t           res_reg, res_next;

    logic signed [COORD_W-1:0] vtx_reg [9];
    logic signed [COORD_W-1:0] vtx_next [9];
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] org_next [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic signed [COORD_W-1:0] dir_next [3];
    logic signed [NRM_W-1:0]   n_reg [3];
    logic signed [NRM_W-1:0]   n_next [3];
    logic signed [DOT_W-1:0]   r_reg, r_next;
    logic signed [DOT_W-1:0]   d_reg, d_next;
    logic [DIST_W-1:0]         lo_reg, lo_next;
    logic [DIST_W-1:0]         hi_reg, hi_next;
    logic [DIST_W-1:0]         t_reg, t_next;
    logic signed [DP_W-1:0]    dpx_reg, dpx_next;
    logic signed [DP_W-1:0]    dpy_reg, dpy_next;
    logic signed [NRM_W-1:0]   det_reg, det_next;
    logic signed [BARY_W-1:0]  u_reg, u_next;
    logic signed [BARY_W-1:0]  v_reg, v_next;

    logic signed [EDGE_W-1:0] e1 [3];
    logic signed [EDGE_W-1:0] e2 [3];
    logic signed [EDGE_W-1:0] rel [3];
    logic signed [EDGE_W-1:0] d0 [2];
    logic signed [EDGE_W-1:0] d1 [2];
    logic signed [EDGE_W-1:0] rel2x;
    logic signed [EDGE_W-1:0] rel2y;

    logic [DIST_W:0]   mid_sum;
    logic [DIST_W-1:0] mid;
    logic [DIST_W-1:0] lo_new;
    logic [DIST_W-1:0] hi_new;
    logic [DIST_W:0]   t_sum;

    uop_t     uop;
    mac_req_t mac_req;
    mac_rsp_t mac_rsp;
    logic     acc_neg;
    logic     acc_pos;

    logic signed [SUM_W-1:0] bary_sum;
    logic det_zero, det_neg, u_neg, u_pos, v_neg, v_pos, s_neg, s_pos, miss;

    rtbh_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    // Edge and offset vectors from the stored vertices.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            e1[c]  = EDGE_W'(vtx_reg[6 + c]) - EDGE_W'(vtx_reg[c]);
            e2[c]  = EDGE_W'(vtx_reg[3 + c]) - EDGE_W'(vtx_reg[c]);
            rel[c] = EDGE_W'(org_reg[c]) - EDGE_W'(vtx_reg[c]);
        end
        for (int c = 0; c < 2; c++)
        begin
            d0[c] = EDGE_W'(vtx_reg[c]) - EDGE_W'(vtx_reg[6 + c]);
            d1[c] = EDGE_W'(vtx_reg[3 + c]) - EDGE_W'(vtx_reg[6 + c]);
        end
        rel2x = EDGE_W'(org_reg[0]) - EDGE_W'(vtx_reg[6]);
        rel2y = EDGE_W'(org_reg[1]) - EDGE_W'(vtx_reg[7]);
    end

    // Bisection midpoint and the interval after this step's sign test.
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[DIST_W:1];
        acc_neg = mac_rsp.acc[ACC_W-1];
        acc_pos = !acc_neg && (mac_rsp.acc != '0);
        lo_new  = acc_pos ? mid : lo_reg;
        hi_new  = acc_pos ? hi_reg : mid;
        t_sum   = {1'b0, lo_new} + {1'b0, hi_new};
    end

    // Operand selection for the current operation.
    always_comb
    begin
        uop = uop_at(pc_reg);
        mac_req.start = (state_reg == S_ISSUE);
        mac_req.keep  = (uop.init == I_KEEP);
        mac_req.neg   = uop.neg;
        case (uop.a_sel)
            A_E1X:   mac_req.a = A_W'(e1[0]);
            A_E1Y:   mac_req.a = A_W'(e1[1]);
            A_E1Z:   mac_req.a = A_W'(e1[2]);
            A_NX:    mac_req.a = A_W'(n_reg[0]);
            A_NY:    mac_req.a = A_W'(n_reg[1]);
            A_NZ:    mac_req.a = A_W'(n_reg[2]);
            A_DIST:  mac_req.a = A_W'(d_reg);
            A_T:     mac_req.a = A_W'(signed'({1'b0, t_reg}));
            A_D0X:   mac_req.a = A_W'(d0[0]);
            A_D0Y:   mac_req.a = A_W'(d0[1]);
            A_DPX:   mac_req.a = A_W'(dpx_reg);
            A_DPY:   mac_req.a = A_W'(dpy_reg);
            default: mac_req.a = '0;
        endcase
        case (uop.b_sel)
            B_E2X:   mac_req.b = B_W'(e2[0]);
            B_E2Y:   mac_req.b = B_W'(e2[1]);
            B_E2Z:   mac_req.b = B_W'(e2[2]);
            B_RELX:  mac_req.b = B_W'(rel[0]);
            B_RELY:  mac_req.b = B_W'(rel[1]);
            B_RELZ:  mac_req.b = B_W'(rel[2]);
            B_DIRX:  mac_req.b = B_W'(dir_reg[0]);
            B_DIRY:  mac_req.b = B_W'(dir_reg[1]);
            B_DIRZ:  mac_req.b = B_W'(dir_reg[2]);
            B_MID:   mac_req.b = B_W'(signed'({1'b0, mid}));
            B_D1X:   mac_req.b = B_W'(d1[0]);
            B_D1Y:   mac_req.b = B_W'(d1[1]);
            B_D0X:   mac_req.b = B_W'(d0[0]);
            B_D0Y:   mac_req.b = B_W'(d0[1]);
            default: mac_req.b = '0;
        endcase
        case (uop.init)
            I_RDIST: mac_req.init = ACC_W'(r_reg) <<< FRAC_W;
            I_PX:    mac_req.init = (uop.dest == D_DPX) ? (ACC_W'(rel2x) <<< FRAC_W)
                                                        : (ACC_W'(rel2y) <<< FRAC_W);
            default: mac_req.init = '0;
        endcase
    end

    // Barycentric decision without division; a negative determinant flips every test.
    always_comb
    begin
        bary_sum = SUM_W'(u_reg) + SUM_W'(v_reg) - (SUM_W'(det_reg) <<< FRAC_W);
        det_zero = (det_reg == '0);
        det_neg  = det_reg[NRM_W-1];
        u_neg    = u_reg[BARY_W-1];
        u_pos    = !u_neg && (u_reg != '0);
        v_neg    = v_reg[BARY_W-1];
        v_pos    = !v_neg && (v_reg != '0);
        s_neg    = bary_sum[SUM_W-1];
        s_pos    = !s_neg && (bary_sum != '0);
        miss     = det_zero || (det_neg ? (u_pos || v_pos || s_neg)
                                        : (u_neg || v_neg || s_pos));
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        step_next      = step_reg;
        rneg_next      = rneg_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        res_next       = res_reg;
        vtx_next       = vtx_reg;
        org_next       = org_reg;
        dir_next       = dir_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        d_next         = d_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        t_next         = t_reg;
        dpx_next       = dpx_reg;
        dpy_next       = dpy_reg;
        det_next       = det_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        pop            = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_nonempty)
                begin
                    pop = 1'b1;
                    if (q_head.mode == MODE_TRACE)
                    begin
                        org_next[0] = q_head.point_x;
                        org_next[1] = q_head.point_y;
                        org_next[2] = q_head.point_z;
                        dir_next[0] = q_head.dir_x;
                        dir_next[1] = q_head.dir_y;
                        dir_next[2] = q_head.dir_z;
                        pc_next     = '0;
                        state_next  = S_ISSUE;
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (q_head.vertex_index == 2'(k))
                            begin
                                vtx_next[k * 3]     = q_head.point_x;
                                vtx_next[k * 3 + 1] = q_head.point_y;
                                vtx_next[k * 3 + 2] = q_head.point_z;
                            end
                        end
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (mac_rsp.done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_ISSUE;
                    case (uop.dest)
                        D_NX: n_next[0] = NRM_W'(mac_rsp.acc);
                        D_NY: n_next[1] = NRM_W'(mac_rsp.acc);
                        D_NZ: n_next[2] = NRM_W'(mac_rsp.acc);
                        D_R:
                        begin
                            // The normal is flipped to face the origin.
                            rneg_next = acc_neg;
                            r_next    = acc_neg ? DOT_W'(-mac_rsp.acc) : DOT_W'(mac_rsp.acc);
                        end
                        D_D:
                        begin
                            d_next    = rneg_reg ? DOT_W'(-mac_rsp.acc) : DOT_W'(mac_rsp.acc);
                            lo_next   = '0;
                            hi_next   = DIST_MAX;
                            step_next = '0;
                            // A ray heading away from the plane misses.
                            if (rneg_reg ? acc_neg : acc_pos)
                            begin
                                res_next   = '{1'b0, '0};
                                state_next = S_OUT;
                            end
                        end
                        D_SIGN:
                        begin
                            lo_next   = lo_new;
                            hi_next   = hi_new;
                            step_next = step_reg + 1'b1;
                            if (step_reg == STEP_W'(SEARCH_STEPS - 1))
                            begin
                                t_next = t_sum[DIST_W:1];
                            end
                            else
                            begin
                                pc_next = pc_reg;
                            end
                        end
                        D_DPX: dpx_next = DP_W'(mac_rsp.acc);
                        D_DPY: dpy_next = DP_W'(mac_rsp.acc);
                        D_DET: det_next = NRM_W'(mac_rsp.acc);
                        D_U:   u_next   = BARY_W'(mac_rsp.acc);
                        D_V:
                        begin
                            v_next     = BARY_W'(mac_rsp.acc);
                            state_next = S_DECIDE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                res_next.hit      = !miss;
                res_next.distance = miss ? '0 : t_reg;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the vertex store, which resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            step_reg      <= '0;
            rneg_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                vtx_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            step_reg      <= step_next;
            rneg_reg      <= rneg_next;
            out_valid_reg <= out_valid_next;
            vtx_reg       <= vtx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        res_reg <= res_next;
        org_reg <= org_next;
        dir_reg <= dir_next;
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        t_reg   <= t_next;
        dpx_reg <= dpx_next;
        dpy_reg <= dpy_next;
        det_reg <= det_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: hw/rtl/ray_triangle_bisection_hit.sv
// Ray/triangle hit test: front end, word queue and sequenced back end.
// Depends on rtbh_pkg, rtbh_front, rtbh_queue and rtbh_back.
//
// Usage: the input channel (item_valid, item_stall, item) carries two kinds of word.
// A load word (mode 0) writes one triangle vertex; vertex index three is dropped.
// A trace word (mode 1) carries a ray origin and direction and yields exactly one
// word on the result channel (result_valid, result_stall, result): hit, and the ray
// parameter in unsigned Q10.16, zero on a miss.
// Words pass through a two-entry queue, so the input keeps accepting while the back
// end works, until the queue fills. The back end takes one word at a time.
// A load is written to the vertex store straight from idle. A trace runs 40 products on
// one shared digit-serial multiply-accumulate unit (each issued, accumulated digit by
// digit and written back), plus steps to take the word, decide and fill the output
// register; a trace ends sooner when the ray faces away from the plane.
// That unit sets the throughput.
// Reset clears the vertices to zero and empties the queue and the output register.
// While the receiver stalls, the result holds in the output register; the back end
// may finish the next trace and then waits with it until the register frees.
module ray_triangle_bisection_hit
    import rtbh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_pop;
    logic  q_nonempty;
    item_t q_head;

    rtbh_front u_front (
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .q_full     (q_full),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    rtbh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    rtbh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule
